// ===== sv/lruwb_pkg.sv =====
`timescale 1ns / 1ps

package lruwb_pkg;

   // Default sizing of the cache.
   localparam int SLOTS_DEF      = 5;
   localparam int OWNER_BITS_DEF = 4;

   // Request operation codes.
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;
   localparam logic [1:0] OP_INVAL = 2'd3;

   // Result kind codes.
   localparam logic [1:0] KIND_WB    = 2'd0;
   localparam logic [1:0] KIND_FILL  = 2'd1;
   localparam logic [1:0] KIND_ACC   = 2'd2;
   localparam logic [1:0] KIND_MAINT = 2'd3;

   // Block size register.
   localparam logic [2:0] LG_RESET = 3'd3;
   localparam logic [2:0] LG_MAX   = 3'd6;

   // Which result beat the datapath builds.
   typedef enum logic [2:0] {
      EMIT_WB_VICTIM = 3'd0,
      EMIT_WB_FLUSH  = 3'd1,
      EMIT_FILL      = 3'd2,
      EMIT_ACC       = 3'd3,
      EMIT_ACC_NULL  = 3'd4,
      EMIT_MAINT     = 3'd5
   } emit_sel_type;

   typedef struct packed {
      logic         latch_req;
      logic         lookup;
      logic         fill;
      logic         touch;
      logic         flush_start;
      logic         flush_next;
      logic         flush_clear;
      logic         inval;
      logic         emit;
      emit_sel_type emit_sel;
   } cmd_type;

   typedef struct packed {
      logic       out_free;
      logic       pid_zero;
      logic [1:0] op;
      logic       hit;
      logic       victim_dirty;
      logic       flush_hit;
      logic       flush_last;
   } status_type;

endpackage

// ===== sv/lruwb_dpath.sv =====
`timescale 1ns / 1ps

module lruwb_dpath #(
   parameter int SLOTS      = lruwb_pkg::SLOTS_DEF,
   parameter int OWNER_BITS = lruwb_pkg::OWNER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [71:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  csr_we,
   input  logic [2:0]            csr_wdata,
   input  lruwb_pkg::cmd_type    cmd,
   output lruwb_pkg::status_type status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int SW = $clog2(SLOTS);
   localparam logic [SW-1:0] LAST_RANK = SW'(SLOTS - 1);

   // Slot state.
   logic [OWNER_BITS-1:0] owner_ff [SLOTS];
   logic [OWNER_BITS-1:0] owner_in [SLOTS];
   logic [31:0]           tag_ff   [SLOTS];
   logic [31:0]           tag_in   [SLOTS];
   logic [31:0]           base_ff  [SLOTS];
   logic [31:0]           base_in  [SLOTS];
   logic [SW-1:0]         rank_ff  [SLOTS];
   logic [SW-1:0]         rank_in  [SLOTS];
   logic [SLOTS-1:0]      dirty_ff;
   logic [SLOTS-1:0]      dirty_in;
   logic [2:0]            lg_ff;

   // Latched request and lookup result.
   logic [1:0]            op_ff;
   logic [OWNER_BITS-1:0] pid_ff;
   logic [31:0]           sector_ff;
   logic [31:0]           reqbase_ff;
   logic                  hit_ff;
   logic [SW-1:0]         sel_ff;
   logic [SW-1:0]         fcnt_ff;

   // Output register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [1:0]            kind_ff;
   logic [1:0]            kind_in;
   logic [2:0]            slot_ff;
   logic [2:0]            slot_in;
   logic [31:0]           addr_ff;
   logic [31:0]           addr_in;
   logic [5:0]            off_ff;
   logic [5:0]            off_in;
   logic                  hitout_ff;
   logic                  hitout_in;
   logic                  last_ff;
   logic                  last_in;

   logic [7:0]            pid_wide;
   logic [2:0]            lg;
   logic [31:0]           omask;
   logic [31:0]           tag;
   logic [5:0]            offset;
   logic                  match_any;
   logic [SW-1:0]         match_idx;
   logic [SW-1:0]         victim_idx;
   logic [SW-1:0]         flush_idx;
   logic [SW-1:0]         wb_idx;
   logic [31:0]           wb_addr;
   logic [31:0]           req_addr;
   logic [SW-1:0]         sel_rank;

   assign pid_wide = {4'b0000, req_tdata[3:0]};

   always_comb begin
      lg        = (lg_ff > lruwb_pkg::LG_MAX) ? lruwb_pkg::LG_MAX : lg_ff;
      omask     = (32'd1 << lg) - 32'd1;
      tag       = sector_ff & ~omask;
      offset    = sector_ff[5:0] & omask[5:0];
      match_any = 1'b0;
      match_idx = '0;
      victim_idx = '0;
      flush_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (owner_ff[i] != '0 && owner_ff[i] == pid_ff && tag_ff[i] == tag) begin
            match_any = 1'b1;
            match_idx = SW'(i);
         end
         if (rank_ff[i] == LAST_RANK) begin
            victim_idx = SW'(i);
         end
         if (rank_ff[i] == fcnt_ff) begin
            flush_idx = SW'(i);
         end
      end
   end

   always_comb begin
      status.out_free     = !rsp_valid_ff || rsp_tready;
      status.pid_zero     = (pid_ff == '0);
      status.op           = op_ff;
      status.hit          = match_any;
      status.victim_dirty = (owner_ff[victim_idx] != '0) && dirty_ff[victim_idx];
      status.flush_hit    = (owner_ff[flush_idx] == pid_ff) && dirty_ff[flush_idx];
      status.flush_last   = (fcnt_ff == LAST_RANK);
   end

   // One adder serves both write-back sources.
   assign wb_idx   = (cmd.emit_sel == lruwb_pkg::EMIT_WB_FLUSH) ? flush_idx : sel_ff;
   assign wb_addr  = base_ff[wb_idx] + tag_ff[wb_idx];
   assign req_addr = reqbase_ff + tag;
   assign sel_rank = rank_ff[sel_ff];

   // Slot state updates; the controller raises one update at a time.
   always_comb begin
      owner_in = owner_ff;
      tag_in   = tag_ff;
      base_in  = base_ff;
      rank_in  = rank_ff;
      dirty_in = dirty_ff;
      if (cmd.fill) begin
         owner_in[sel_ff] = pid_ff;
         tag_in[sel_ff]   = tag;
         base_in[sel_ff]  = reqbase_ff;
         dirty_in[sel_ff] = 1'b0;
      end
      if (cmd.touch) begin
         if (op_ff == lruwb_pkg::OP_WRITE) begin
            dirty_in[sel_ff] = 1'b1;
         end
         for (int i = 0; i < SLOTS; i++) begin
            if (SW'(i) == sel_ff) begin
               rank_in[i] = '0;
            end else if (rank_ff[i] < sel_rank) begin
               rank_in[i] = rank_ff[i] + SW'(1);
            end
         end
      end
      if (cmd.flush_clear) begin
         dirty_in[flush_idx] = 1'b0;
      end
      if (cmd.inval) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (owner_ff[i] == pid_ff) begin
               owner_in[i] = '0;
               tag_in[i]   = '1;
               dirty_in[i] = 1'b0;
            end
         end
      end
   end

   // Result beat assembly.
   always_comb begin
      kind_in   = lruwb_pkg::KIND_MAINT;
      slot_in   = 3'd0;
      addr_in   = 32'd0;
      off_in    = 6'd0;
      hitout_in = 1'b0;
      last_in   = 1'b0;
      case (cmd.emit_sel)
         lruwb_pkg::EMIT_WB_VICTIM, lruwb_pkg::EMIT_WB_FLUSH: begin
            kind_in = lruwb_pkg::KIND_WB;
            slot_in = 3'(wb_idx);
            addr_in = wb_addr;
         end
         lruwb_pkg::EMIT_FILL: begin
            kind_in = lruwb_pkg::KIND_FILL;
            slot_in = 3'(sel_ff);
            addr_in = req_addr;
         end
         lruwb_pkg::EMIT_ACC: begin
            kind_in   = lruwb_pkg::KIND_ACC;
            slot_in   = 3'(sel_ff);
            addr_in   = req_addr;
            off_in    = offset;
            hitout_in = hit_ff;
            last_in   = 1'b1;
         end
         lruwb_pkg::EMIT_ACC_NULL: begin
            kind_in = lruwb_pkg::KIND_ACC;
            last_in = 1'b1;
         end
         default: begin
            kind_in = lruwb_pkg::KIND_MAINT;
            last_in = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            owner_ff[i] <= '0;
            tag_ff[i]   <= '1;
            base_ff[i]  <= '0;
            rank_ff[i]  <= SW'(i);
         end
         dirty_ff     <= '0;
         lg_ff        <= lruwb_pkg::LG_RESET;
         rsp_valid_ff <= 1'b0;
         fcnt_ff      <= '0;
      end else begin
         owner_ff     <= owner_in;
         tag_ff       <= tag_in;
         base_ff      <= base_in;
         rank_ff      <= rank_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            lg_ff <= csr_wdata;
         end
         if (cmd.flush_start) begin
            fcnt_ff <= '0;
         end else if (cmd.flush_next) begin
            fcnt_ff <= fcnt_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff      <= req_tuser;
         pid_ff     <= pid_wide[OWNER_BITS-1:0];
         sector_ff  <= req_tdata[35:4];
         reqbase_ff <= req_tdata[67:36];
      end
      if (cmd.lookup) begin
         hit_ff <= match_any;
         sel_ff <= match_any ? match_idx : victim_idx;
      end
      if (cmd.emit) begin
         kind_ff   <= kind_in;
         slot_ff   <= slot_in;
         addr_ff   <= addr_in;
         off_ff    <= off_in;
         hitout_ff <= hitout_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {6'd0, hitout_ff, off_ff, addr_ff, slot_ff};

endmodule

// ===== sv/lruwb_ctrl.sv =====
`timescale 1ns / 1ps

module lruwb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  lruwb_pkg::status_type status,
   output lruwb_pkg::cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_DECODE = 10'b00_0000_0010,
      ST_LOOKUP = 10'b00_0000_0100,
      ST_EVICT  = 10'b00_0000_1000,
      ST_FILL   = 10'b00_0001_0000,
      ST_ACCESS = 10'b00_0010_0000,
      ST_NULL   = 10'b00_0100_0000,
      ST_FLUSH  = 10'b00_1000_0000,
      ST_INVAL  = 10'b01_0000_0000,
      ST_MAINT  = 10'b10_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.emit_sel = lruwb_pkg::EMIT_MAINT;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.pid_zero) begin
               if (status.op == lruwb_pkg::OP_READ || status.op == lruwb_pkg::OP_WRITE) begin
                  state_in = ST_NULL;
               end else begin
                  state_in = ST_MAINT;
               end
            end else if (status.op == lruwb_pkg::OP_FLUSH) begin
               cmd.flush_start = 1'b1;
               state_in        = ST_FLUSH;
            end else if (status.op == lruwb_pkg::OP_INVAL) begin
               state_in = ST_INVAL;
            end else begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            if (status.hit) begin
               state_in = ST_ACCESS;
            end else if (status.victim_dirty) begin
               state_in = ST_EVICT;
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_EVICT: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = lruwb_pkg::EMIT_WB_VICTIM;
               state_in     = ST_FILL;
            end
         end
         ST_FILL: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = lruwb_pkg::EMIT_FILL;
               cmd.fill     = 1'b1;
               state_in     = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = lruwb_pkg::EMIT_ACC;
               cmd.touch    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_NULL: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = lruwb_pkg::EMIT_ACC_NULL;
               state_in     = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            // A clean or foreign slot is skipped without waiting on the output.
            if (!status.flush_hit || status.out_free) begin
               if (status.flush_hit) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_sel    = lruwb_pkg::EMIT_WB_FLUSH;
                  cmd.flush_clear = 1'b1;
               end
               if (status.flush_last) begin
                  state_in = ST_MAINT;
               end else begin
                  cmd.flush_next = 1'b1;
               end
            end
         end
         ST_INVAL: begin
            cmd.inval = 1'b1;
            state_in  = ST_MAINT;
         end
         ST_MAINT: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = lruwb_pkg::EMIT_MAINT;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/lru_writeback_block_cache.sv =====
`timescale 1ns / 1ps

// Tag and replacement controller for a small fully associative write-back
// block cache shared by several partitions. Requests arrive as beats on the
// req_ channel; each request produces one or more result beats on the rsp_
// channel, and rsp_tlast marks the final beat of a request.
// A request is taken only when the block is idle. A read or write that hits
// passes decode, lookup and access states, loading its single beat into the
// output register in the access state; a miss adds a fill state for the fill
// beat and, for a dirty victim, an evict state. A flush walks the slots in
// recency order, one slot per cycle unless a write-back beat waits on a
// stalled receiver, loading each write-back beat as it visits the slot. An
// invalidate passes decode, invalidate and maintenance states; a partition
// zero request passes decode, then null or maintenance. The controller moves
// one beat per cycle, unless stalled, through a single output register.
// A synchronous reset empties every slot, restores the recency order so that
// slot i has rank i, clears the output valid flag and sets the block size
// register to 8 sectors. The block size register may be written at any idle
// time through csr_we and csr_wdata.
// When the receiver holds rsp_tready low the pending beat stays in the output
// register and the controller waits before issuing the next one.

module lru_writeback_block_cache #(
   parameter int SLOTS      = lruwb_pkg::SLOTS_DEF,
   parameter int OWNER_BITS = lruwb_pkg::OWNER_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // partition_id[3:0], sector_index[35:4],
                                    // partition_base[67:36], zero fill above
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // slot[2:0], device_block_addr[34:3],
                                    // sector_offset[40:35], hit[41], zero fill
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast,   // last
   // Block size register, log2 of sectors per block.
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata
);

   // The controller only sequences; all slot state lives in the datapath.
   lruwb_pkg::cmd_type    cmd;
   lruwb_pkg::status_type status;

   lruwb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lruwb_dpath #(
      .SLOTS      (SLOTS),
      .OWNER_BITS (OWNER_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/lru_writeback_block_cache_tb.sv =====
`timescale 1ns / 1ps

module lru_writeback_block_cache_tb;

   localparam int SLOTS = lruwb_pkg::SLOTS_DEF;
   localparam int DRAIN_CYCLES = SLOTS + 12;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  slot;
      logic [31:0] addr;
      logic [5:0]  offset;
      logic        hit;
      logic        last;
   } cache_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_wdata = '0;

   // Shadow of the cache tags, recency order and block size register.
   logic [3:0]  tag_owner [SLOTS];
   logic [31:0] tag_block [SLOTS];
   logic [31:0] tag_base  [SLOTS];
   logic        tag_dirty [SLOTS];
   int          recency   [SLOTS];
   logic [2:0]  blk_lg;

   cache_beat_type pending_beats[$];
   int          fail_count = 0;
   bit          idle_on = 1'b1;
   bit          hold_off = 1'b0;

   logic [31:0] block_pool [6];
   logic [31:0] part_base  [16];

   lru_writeback_block_cache dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int slot_at_rank(input int r);
      int i;
      for (i = 0; i < SLOTS; i++)
         if (recency[i] == r) return i;
      return 0;
   endfunction

   function automatic void make_most_recent(input int s);
      int i;
      int r;
      r = recency[s];
      for (i = 0; i < SLOTS; i++)
         if (recency[i] < r) recency[i]++;
      recency[s] = 0;
   endfunction

   function automatic void push_beat(input logic [1:0] kind, input int slot,
                                     input logic [31:0] addr, input logic [5:0] offset,
                                     input logic hit, input logic last);
      cache_beat_type b;
      b.kind   = kind;
      b.slot   = 3'(slot);
      b.addr   = addr;
      b.offset = offset;
      b.hit    = hit;
      b.last   = last;
      pending_beats.push_back(b);
   endfunction

   function automatic void clear_shadow();
      int i;
      for (i = 0; i < SLOTS; i++) begin
         tag_owner[i] = '0;
         tag_block[i] = '1;
         tag_base[i]  = '0;
         tag_dirty[i] = 1'b0;
         recency[i]   = i;
      end
      blk_lg = lruwb_pkg::LG_RESET;
   endfunction

   // Works out every result beat that one accepted request causes.
   function automatic void predict_request(input logic [1:0] op, input logic [3:0] pid,
                                           input logic [31:0] sector,
                                           input logic [31:0] pbase);
      logic [2:0]  lg;
      logic [31:0] omask;
      logic [31:0] btag;
      logic        was_hit;
      int          s;
      int          r;
      int          c;
      lg = (blk_lg > lruwb_pkg::LG_MAX) ? lruwb_pkg::LG_MAX : blk_lg;
      omask = (32'd1 << lg) - 32'd1;
      btag = sector & ~omask;
      if (pid == 4'd0) begin
         // The reserved partition touches nothing and just answers done.
         push_beat((op == lruwb_pkg::OP_READ || op == lruwb_pkg::OP_WRITE) ?
                   lruwb_pkg::KIND_ACC : lruwb_pkg::KIND_MAINT,
                   0, '0, '0, 1'b0, 1'b1);
      end else if (op == lruwb_pkg::OP_FLUSH) begin
         for (r = 0; r < SLOTS; r++) begin
            s = slot_at_rank(r);
            if (tag_owner[s] == pid && tag_dirty[s]) begin
               tag_dirty[s] = 1'b0;
               push_beat(lruwb_pkg::KIND_WB, s, tag_base[s] + tag_block[s], '0,
                         1'b0, 1'b0);
            end
         end
         push_beat(lruwb_pkg::KIND_MAINT, 0, '0, '0, 1'b0, 1'b1);
      end else if (op == lruwb_pkg::OP_INVAL) begin
         // Every slot of the partition goes, not only the first one found.
         for (s = 0; s < SLOTS; s++) begin
            if (tag_owner[s] == pid) begin
               tag_owner[s] = '0;
               tag_block[s] = '1;
               tag_dirty[s] = 1'b0;
            end
         end
         push_beat(lruwb_pkg::KIND_MAINT, 0, '0, '0, 1'b0, 1'b1);
      end else begin
         s = -1;
         for (r = 0; r < SLOTS && s < 0; r++) begin
            c = slot_at_rank(r);
            if (tag_owner[c] != 4'd0 && tag_owner[c] == pid && tag_block[c] == btag)
               s = c;
         end
         was_hit = (s >= 0);
         if (!was_hit) begin
            s = slot_at_rank(SLOTS - 1);
            if (tag_owner[s] != 4'd0 && tag_dirty[s])
               push_beat(lruwb_pkg::KIND_WB, s, tag_base[s] + tag_block[s], '0,
                         1'b0, 1'b0);
            tag_owner[s] = pid;
            tag_block[s] = btag;
            tag_base[s]  = pbase;
            tag_dirty[s] = 1'b0;
            push_beat(lruwb_pkg::KIND_FILL, s, pbase + btag, '0, 1'b0, 1'b0);
         end
         if (op == lruwb_pkg::OP_WRITE) tag_dirty[s] = 1'b1;
         make_most_recent(s);
         push_beat(lruwb_pkg::KIND_ACC, s, pbase + btag, 6'(sector & omask), was_hit,
                   1'b1);
      end
   endfunction

   // Offers one request beat and holds it until it is taken.
   task automatic issue_request(input logic [1:0] op, input logic [3:0] pid,
                                input logic [31:0] sector, input logic [31:0] pbase);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, pbase, sector, pid};
      do @(posedge clock); while (!req_tready);
      predict_request(op, pid, sector, pbase);
      if (idle_on && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every expected beat has come and the controller is idle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_block_size(input logic [2:0] lg);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= lg;
      @(posedge clock);
      blk_lg = lg;
      csr_we <= 1'b0;
   endtask

   task automatic field_check(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Every result beat is matched against the oldest expectation.
   always @(posedge clock) begin
      cache_beat_type exp_b;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            $error("unexpected result beat: kind %0d tdata 0x%0h", rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            exp_b = pending_beats.pop_front();
            field_check("kind", 32'(exp_b.kind), 32'(rsp_tuser));
            field_check("slot", 32'(exp_b.slot), 32'(rsp_tdata[2:0]));
            field_check("device_block_addr", exp_b.addr, rsp_tdata[34:3]);
            field_check("sector_offset", 32'(exp_b.offset), 32'(rsp_tdata[40:35]));
            field_check("hit", 32'(exp_b.hit), 32'(rsp_tdata[41]));
            field_check("last", 32'(exp_b.last), 32'(rsp_tlast));
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 8);
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic random_request();
      logic [1:0]  op;
      logic [3:0]  pid;
      logic [31:0] sector;
      logic [31:0] pbase;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         op = ($urandom_range(0, 1) == 0) ? lruwb_pkg::OP_READ : lruwb_pkg::OP_WRITE;
      else if (pick < 86)
         op = lruwb_pkg::OP_FLUSH;
      else
         op = lruwb_pkg::OP_INVAL;
      pick = $urandom_range(0, 99);
      if (pick < 3)       pid = 4'd0;
      else if (pick < 80) pid = 4'($urandom_range(1, 3));
      else                pid = 4'($urandom_range(1, 15));
      // Mostly sectors near a few hot blocks so that hits and evictions mix.
      pick = $urandom_range(0, 99);
      if (pick < 45)
         sector = {block_pool[$urandom_range(0, 5)][31:6], 6'($urandom_range(0, 3))};
      else if (pick < 85)
         sector = {block_pool[$urandom_range(0, 5)][31:6], 6'($urandom)};
      else
         sector = $urandom;
      pbase = ($urandom_range(0, 9) == 0) ? 32'($urandom) : part_base[pid];
      issue_request(op, pid, sector, pbase);
   endtask

   task automatic test_hit_and_miss();
      // An empty slot holds the all-ones tag but must never hit.
      issue_request(lruwb_pkg::OP_READ,  4'd1, 32'hFFFF_FFFF, 32'h0000_0000);
      issue_request(lruwb_pkg::OP_READ,  4'd1, 32'hFFFF_FFF8, 32'h0000_0000);
      issue_request(lruwb_pkg::OP_WRITE, 4'd1, 32'hFFFF_FFF9, 32'h0000_0000);
      issue_request(lruwb_pkg::OP_WRITE, 4'd15, 32'h0000_0000, 32'hFFFF_FFFF);
      issue_request(lruwb_pkg::OP_READ,  4'd2, 32'h0000_0100, 32'h0000_1000);
      issue_request(lruwb_pkg::OP_WRITE, 4'd2, 32'h0000_0208, 32'h0000_1000);
      issue_request(lruwb_pkg::OP_READ,  4'd2, 32'h0000_0310, 32'h0000_1000);
      // The cache is full; these evict dirty victims first.
      issue_request(lruwb_pkg::OP_READ,  4'd3, 32'h0000_0040, 32'h8000_0000);
      issue_request(lruwb_pkg::OP_WRITE, 4'd4, 32'h0000_0027, 32'hFFFF_FFF0);
      // Same tag, other partition: must miss.
      issue_request(lruwb_pkg::OP_READ,  4'd3, 32'h0000_0100, 32'h8000_0000);
   endtask

   task automatic test_reserved_partition();
      issue_request(lruwb_pkg::OP_READ,  4'd0, 32'h0000_0100, 32'h0000_1000);
      issue_request(lruwb_pkg::OP_WRITE, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue_request(lruwb_pkg::OP_FLUSH, 4'd0, 32'h0, 32'h0);
      issue_request(lruwb_pkg::OP_INVAL, 4'd0, 32'h0, 32'h0);
   endtask

   task automatic test_maintenance();
      issue_request(lruwb_pkg::OP_WRITE, 4'd2, 32'h0000_0500, 32'h0000_1000);
      issue_request(lruwb_pkg::OP_WRITE, 4'd2, 32'h0000_0600, 32'h0000_1000);
      issue_request(lruwb_pkg::OP_FLUSH, 4'd2, 32'h0, 32'h0);
      issue_request(lruwb_pkg::OP_FLUSH, 4'd2, 32'h0, 32'h0);
      issue_request(lruwb_pkg::OP_FLUSH, 4'd9, 32'h0, 32'h0);
      issue_request(lruwb_pkg::OP_WRITE, 4'd2, 32'h0000_0500, 32'h0000_1000);
      issue_request(lruwb_pkg::OP_INVAL, 4'd2, 32'h0, 32'h0);
      issue_request(lruwb_pkg::OP_READ,  4'd2, 32'h0000_0600, 32'h0000_1000);
   endtask

   task automatic test_block_size();
      set_block_size(3'd0);
      issue_request(lruwb_pkg::OP_WRITE, 4'd1, 32'h1234_5677, 32'h0000_4000);
      issue_request(lruwb_pkg::OP_READ,  4'd1, 32'h1234_5677, 32'h0000_4000);
      issue_request(lruwb_pkg::OP_READ,  4'd1, 32'h1234_5678, 32'h0000_4000);
      // A setting of seven behaves like six.
      set_block_size(3'd7);
      issue_request(lruwb_pkg::OP_READ,  4'd1, 32'hABCD_EF3F, 32'h0000_4000);
      set_block_size(3'd6);
      issue_request(lruwb_pkg::OP_READ,  4'd1, 32'hABCD_EF00, 32'h0000_4000);
   endtask

   task automatic test_backpressure();
      int i;
      hold_off = 1'b1;
      for (i = 0; i < 12; i++) random_request();
   endtask

   task automatic test_random_traffic();
      logic [2:0] lg_order [8];
      int         p;
      int         i;
      lg_order = '{3'd3, 3'd0, 3'd6, 3'd1, 3'd7, 3'd2, 3'd5, 3'd4};
      for (i = 0; i < 6; i++) block_pool[i] = $urandom;
      for (i = 0; i < 16; i++) part_base[i] = $urandom;
      test_backpressure();
      for (p = 0; p < 8; p++) begin
         set_block_size(lg_order[p]);
         if (p == 7) idle_on = 1'b0;
         for (i = 0; i < 45; i++) random_request();
      end
   endtask

   initial begin
      clear_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_hit_and_miss();
      test_reserved_partition();
      test_maintenance();
      test_block_size();
      test_random_traffic();
      wait_drained();
      if (fail_count == 0)
         $display("[lru_writeback_block_cache] OK");
      else
         $display("[lru_writeback_block_cache] ERROR");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("[lru_writeback_block_cache] ERROR");
      $finish;
   end

endmodule
